// ===== sv/rss_pkg.sv =====
// package: item types and register indexes of the replica spread selector
`timescale 1ns / 1ps

package rss_pkg;

  localparam int MAP_BITS = 16;
  localparam int CFG_W    = 5;

  localparam logic REG_REPLICA_TOTAL = 1'b0;
  localparam logic REG_SPREAD_LIMIT  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  dir_slot;
    logic [15:0] dir_map;
    logic [4:0]  dir_used;
  } req_t;

  typedef struct packed {
    logic [3:0] replica_pick;
    logic       none_found;
  } res_t;

endpackage

// ===== sv/replica_spread_selector.sv =====
// top level: replica spread selector with directory pointer memory
//
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------
// request   | start, busy         | req (operation, slot, map, used)
// result    | done (one cycle)    | res (replica_pick, none_found)
// config    | cfg_we              | cfg_index, cfg_data
//
// a round robin item first reads the pointer memory, then picks and writes the pointer back.
// a spread item is evaluated, then draws from the counter until it finds a free replica (up to
// 24 draws at WRAP_LIMIT 1024; a counter wrap inside the search can run past the replica count).
// after a replica_total write, the next spread item that draws adds a WRAP_LIMIT bit-width
// remainder pass to bring the counter residue up to date.
// after reset a clearing pass writes zero to every pointer memory slot with busy high.
// results cannot be stalled; busy stays high until the result of the current item is out.
`timescale 1ns / 1ps

module replica_spread_selector
  import rss_pkg::*;
#(
  parameter int MAX_REPLICAS = 16,
  parameter int DIR_SLOTS    = 256,
  parameter int WRAP_LIMIT   = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output res_t             res,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CAP = (MAX_REPLICAS < MAP_BITS) ? MAX_REPLICAS : MAP_BITS;
  localparam int SW  = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int CW  = $clog2(WRAP_LIMIT + 1);
  localparam int BW  = $clog2(CW);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_DRAW  = 3'd4;

  logic [2:0]       state;
  logic [CFG_W-1:0] replica_total;
  logic [CFG_W-1:0] spread_limit;
  logic [CW-1:0]    counter;
  logic [4:0]       resid;
  logic             resid_ok;
  logic [4:0]       rem;
  logic [BW-1:0]    bcnt;
  logic [SW-1:0]    clr_idx;
  req_t             item;
  logic [SW-1:0]    item_slot;

  logic [3:0]       ptr_mem [DIR_SLOTS];
  logic [3:0]       ptr_rd;
  logic             mem_we;
  logic [SW-1:0]    mem_waddr;
  logic [3:0]       mem_wdata;

  logic [12:0]      acc;
  logic [SW-1:0]    slot_idx;
  logic [4:0]       r;
  logic [4:0]       span;
  logic [MAP_BITS-1:0] mask_r;
  logic [MAP_BITS-1:0] elig;
  logic [MAP_BITS-1:0] elig_hi;
  logic [3:0]       p;
  logic [3:0]       rr_pick;
  logic             rr_found;
  logic             any_free;
  logic [4:0]       pick_inc;
  logic [3:0]       ptr_next;
  logic             accept;
  logic             wrap;
  logic [4:0]       resid_next;
  logic [4:0]       rem_sh;
  logic [4:0]       rem_next;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // slot modulo the memory depth, one compare and subtract per input bit
  always_comb begin
    acc = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[11:0], req.dir_slot[i]};
      if (acc >= 13'(DIR_SLOTS)) acc = acc - 13'(DIR_SLOTS);
    end
    slot_idx = acc[SW-1:0];
  end

  always_comb begin
    if (replica_total == '0) r = 5'd1;
    else if (replica_total > 5'(CAP)) r = 5'(CAP);
    else r = replica_total;
    span = (spread_limit < r) ? spread_limit : r;
    for (int i = 0; i < MAP_BITS; i++) mask_r[i] = (5'(i) < r);
  end

  // round robin search from the stored pointer
  always_comb begin
    p        = (5'(ptr_rd) >= r) ? 4'd0 : ptr_rd;
    elig     = item.dir_map & mask_r;
    any_free = |(~item.dir_map & mask_r);
    for (int i = 0; i < MAP_BITS; i++) elig_hi[i] = elig[i] && (4'(i) >= p);
    rr_found = |elig;
    rr_pick  = '0;
    if (|elig_hi) begin
      for (int i = MAP_BITS - 1; i >= 0; i--) if (elig_hi[i]) rr_pick = 4'(i);
    end else begin
      for (int i = MAP_BITS - 1; i >= 0; i--) if (elig[i]) rr_pick = 4'(i);
    end
    pick_inc = {1'b0, rr_pick} + 5'd1;
    ptr_next = (pick_inc == r) ? 4'd0 : pick_inc[3:0];
  end

  always_comb begin
    wrap       = (counter == CW'(WRAP_LIMIT));
    resid_next = (resid + 5'd1 == r) ? 5'd0 : resid + 5'd1;
    rem_sh     = {rem[3:0], counter[bcnt]};
    rem_next   = (rem_sh >= r) ? rem_sh - r : rem_sh;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_slot;
    mem_wdata = ptr_next;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (state == S_EVAL) begin
      mem_we = !(item.operation == 1'b0 && item.dir_used < span) &&
               !(item.operation == 1'b1 && item.dir_used == '0) && rr_found;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ptr_mem[mem_waddr] <= mem_wdata;
    ptr_rd <= ptr_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      replica_total <= 5'd1;
      spread_limit  <= 5'd4;
      counter       <= '0;
      resid         <= '0;
      resid_ok      <= 1'b1;
      clr_idx       <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_REPLICA_TOTAL) begin
          replica_total <= cfg_data;
          resid_ok      <= 1'b0;
        end else begin
          spread_limit <= cfg_data;
        end
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SW'(DIR_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state <= S_EVAL;
        end
        S_EVAL: begin
          if (item.operation == 1'b0 && item.dir_used < span) begin
            if (!any_free) begin
              done  <= 1'b1;
              res   <= '{replica_pick: 4'd0, none_found: 1'b1};
              state <= S_IDLE;
            end else if (r == 5'd1) begin
              done  <= 1'b1;
              res   <= '{replica_pick: 4'd0, none_found: 1'b0};
              state <= S_IDLE;
            end else if (resid_ok) begin
              state <= S_DRAW;
            end else begin
              rem   <= '0;
              bcnt  <= BW'(CW - 1);
              state <= S_MOD;
            end
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
            if ((item.operation == 1'b1 && item.dir_used == '0) || !rr_found) begin
              res <= '{replica_pick: 4'd0, none_found: 1'b1};
            end else begin
              res <= '{replica_pick: rr_pick, none_found: 1'b0};
            end
          end
        end
        S_MOD: begin
          rem  <= rem_next;
          bcnt <= bcnt - 1'b1;
          if (bcnt == '0) begin
            resid    <= rem_next;
            resid_ok <= 1'b1;
            state    <= S_DRAW;
          end
        end
        S_DRAW: begin
          counter <= wrap ? '0 : counter + 1'b1;
          resid   <= wrap ? '0 : resid_next;
          if (!item.dir_map[resid[3:0]]) begin
            done  <= 1'b1;
            res   <= '{replica_pick: resid[3:0], none_found: 1'b0};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= req;
      item_slot <= slot_idx;
    end
  end

endmodule

// ===== tb/sv/replica_spread_selector_tb.sv =====
// testbench: replica spread selector checked against an in-bench pick predictor
`timescale 1ns / 1ps

module replica_spread_selector_tb;
  import rss_pkg::*;

  localparam logic OP_PLACE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;
  localparam int   SLOTS     = 256;
  localparam int   WRAP      = 1024;
  localparam int   MAX_DRAWS = 4 * MAP_BITS + 4;
  localparam int   PHASES    = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             done;
  res_t             res;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_REPLICA_TOTAL;
  logic [CFG_W-1:0] cfg_data = '0;

  req_t reqs_to_send[$];
  res_t picks_due[$];

  // predictor state
  logic [4:0] m_total;
  logic [4:0] m_limit;
  int         m_draws;
  logic [3:0] m_ptr[SLOTS];

  int  gap_left = 0;
  bit  idle_on = 1'b1;
  int  n_items = 0;
  int  n_results = 0;
  int  n_none = 0;
  int  n_writes = 0;
  int  n_errors = 0;

  replica_spread_selector u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string what);
    if (n_errors < 40) $display("%0t mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic res_t pick_replica(req_t rq);
    int   r, span, p, c, i, k;
    bit   ok, any;
    res_t o;
    r = int'(m_total);
    if (r < 1) r = 1;
    if (r > MAP_BITS) r = MAP_BITS;
    span = (int'(m_limit) < r) ? int'(m_limit) : r;
    ok = 1'b0;
    o = '0;
    if (rq.operation == OP_PLACE && int'(rq.dir_used) < span) begin
      any = 1'b0;
      for (i = 0; i < r; i++) if (!rq.dir_map[i]) any = 1'b1;
      for (k = 0; k < MAX_DRAWS && any && !ok; k++) begin
        if (r == 1) begin
          c = 0;
        end else begin
          c = m_draws % r;
          m_draws = (m_draws + 1 > WRAP) ? 0 : m_draws + 1;
        end
        if (!rq.dir_map[c]) begin
          ok = 1'b1;
          o.replica_pick = 4'(c);
        end
      end
    end else if (!(rq.operation == OP_SELECT && rq.dir_used == 0)) begin
      p = int'(m_ptr[rq.dir_slot]);
      if (p >= r) p = 0;
      for (k = 0; k < r && !ok; k++) begin
        if (rq.dir_map[p]) begin
          ok = 1'b1;
          o.replica_pick = 4'(p);
          m_ptr[rq.dir_slot] = 4'((p + 1) % r);
        end else begin
          p = (p + 1) % r;
        end
      end
    end
    o.none_found = !ok;
    return o;
  endfunction

  function automatic req_t rand_req();
    req_t rq;
    rq.operation = $urandom_range(0, 1) ? OP_SELECT : OP_PLACE;
    rq.dir_slot = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                                8'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: rq.dir_map = 16'($urandom());
      1: rq.dir_map = 16'h1 << $urandom_range(0, 15);
      2: rq.dir_map = ~(16'h1 << $urandom_range(0, 15));
      3: rq.dir_map = 16'($urandom() & $urandom());
      4: rq.dir_map = 16'($urandom() | $urandom());
      default: rq.dir_map = $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
    endcase
    rq.dir_used = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                                                5'($urandom_range(0, 16));
    return rq;
  endfunction

  task automatic queue_req(logic op, int slot, int map, int used);
    req_t rq;
    rq.operation = op;
    rq.dir_slot = 8'(slot);
    rq.dir_map = 16'(map);
    rq.dir_used = 5'(used);
    reqs_to_send.push_back(rq);
  endtask

  task automatic write_reg(logic idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REPLICA_TOTAL) m_total = val[4:0];
    else m_limit = val[4:0];
    n_writes++;
  endtask

  // wait until the block is idle with nothing queued or owed
  task automatic drain();
    int quiet;
    quiet = 0;
    while (quiet < 2) begin
      @(posedge clk);
      if (reqs_to_send.size() == 0 && !start && !busy && picks_due.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        picks_due.push_back(pick_replica(req));
        n_items++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (idle_on && reqs_to_send.size() != 0 && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 17);
        start <= 1'b0;
      end else if (reqs_to_send.size() != 0) begin
        req <= reqs_to_send.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (res.none_found) n_none++;
      if (picks_due.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        res_t want;
        want = picks_due.pop_front();
        if (res.replica_pick !== want.replica_pick)
          report_mismatch($sformatf("replica_pick %0d, expected %0d",
                                    res.replica_pick, want.replica_pick));
        if (res.none_found !== want.none_found)
          report_mismatch($sformatf("none_found %0d, expected %0d",
                                    res.none_found, want.none_found));
      end
    end
  end

  initial begin
    int ph, i;
    int totals[PHASES];
    int limits[PHASES];
    totals = '{16, 1, 2, 5, 16, 7, 0, 31, 9, 16};
    limits = '{16, 1, 16, 3, 1, 0, 20, 5, 9, 4};
    m_total = 5'd1;
    m_limit = 5'd4;
    m_draws = 0;
    foreach (m_ptr[j]) m_ptr[j] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: single replica
    queue_req(OP_PLACE, 0, 16'h0000, 0);
    queue_req(OP_PLACE, 255, 16'h0001, 0);
    queue_req(OP_SELECT, 0, 16'hffff, 0);
    queue_req(OP_SELECT, 255, 16'hffff, 16);
    queue_req(OP_PLACE, 3, 16'h0000, 16);
    drain();

    write_reg(REG_REPLICA_TOTAL, 16);
    write_reg(REG_SPREAD_LIMIT, 16);
    for (i = 0; i < 3; i++) queue_req(OP_PLACE, 1, 16'h0000, 0);
    queue_req(OP_PLACE, 1, 16'hfffe, 15);
    queue_req(OP_PLACE, 1, 16'hffff, 3);
    for (i = 0; i < 3; i++) queue_req(OP_SELECT, 7, 16'h8001, 2);
    queue_req(OP_SELECT, 9, 16'h4000, 1);
    queue_req(OP_SELECT, 255, 16'hffff, 16);
    queue_req(OP_PLACE, 2, 16'h00ff, 16);
    drain();

    // stale pointer and zero limit
    write_reg(REG_REPLICA_TOTAL, 3);
    write_reg(REG_SPREAD_LIMIT, 0);
    queue_req(OP_SELECT, 9, 16'h0007, 3);
    queue_req(OP_PLACE, 4, 16'h0000, 0);
    queue_req(OP_PLACE, 4, 16'h0006, 0);
    drain();

    // replica count clamped at both ends
    write_reg(REG_REPLICA_TOTAL, 0);
    write_reg(REG_SPREAD_LIMIT, 31);
    queue_req(OP_PLACE, 5, 16'h0000, 0);
    queue_req(OP_SELECT, 5, 16'h0002, 1);
    drain();
    write_reg(REG_REPLICA_TOTAL, 31);
    queue_req(OP_PLACE, 6, 16'h7fff, 1);
    queue_req(OP_SELECT, 6, 16'h8000, 30);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_REPLICA_TOTAL, totals[ph]);
      write_reg(REG_SPREAD_LIMIT, limits[ph]);
      idle_on = (ph < PHASES - 1);
      for (i = 0; i < 100; i++) reqs_to_send.push_back(rand_req());
    end

    drain();
    repeat (40) @(posedge clk);
    $display("ran %0d items over %0d register writes: %0d results, %0d with no replica",
             n_items, n_writes, n_results, n_none);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still owed", picks_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
